// ===== hdl/chte_pkg.sv =====
// ----------------------------------------------------------------------------
// chte_pkg: shared types for the coalesced hash table engine
// Holds the request and response formats, command and status codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package chte_pkg;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_GET_OR_INSERT = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_INSERTED = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_TABLE_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [63:0] lookup_key;
		logic [63:0] write_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [63:0] read_value;
		logic [9:0] slot_index;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHAIN,
		S_FREE,
		S_RELINK,
		S_MOVE,
		S_APPEND,
		S_NEW,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/chte_stream_if.sv =====
// ----------------------------------------------------------------------------
// chte_stream_if: valid/ready channel
// Carries one payload item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface chte_stream_if #(parameter type item_t = logic);
	logic valid;
	logic ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/chte_slot_ram.sv =====
// ----------------------------------------------------------------------------
// chte_slot_ram: slot storage
// One write port, one read port, registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none
module chte_slot_ram #(
	parameter int WIDTH = 140,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/coalesced_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// coalesced_hash_table_engine: key/value table with coalesced chaining
// Sequencer around one slot memory that walks chains, scans for free slots
// and relocates foreign occupants of a main slot.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the slot memory once, clearing every slot,
// and accepts no request meanwhile. Each request then takes one transaction on
// req and returns exactly one on rsp. Every step uses the single slot memory:
// a hit or a lookup miss walks the chain one link per read; an insert into an
// occupied main slot also scans slots from index 0 up to the first free one,
// walks links to find a moved foreign occupant's predecessor, and writes the
// changed links and slots. Requests are handled one at a time; a finished
// response waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module coalesced_hash_table_engine #(
	parameter int SLOTS = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	chte_stream_if.sink req,
	chte_stream_if.source rsp
);
	import chte_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
	localparam logic [IW:0] FULL_COUNT = (IW+1)'(SLOTS);

	typedef struct packed {
		logic used;
		logic [63:0] key;
		logic [63:0] value;
		logic [IW:0] link;
	} slot_t;

	state_t state_q, state_d;

	// memory port
	logic ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	slot_t ram_wdata, rd;

	// request context
	logic [1:0] cmd_q;
	logic [63:0] key_q, wval_q;
	logic [IW-1:0] node_q, steps_q, scan_q, p_q, target_q, clr_q;
	slot_t mpw_q, tailw_q;
	logic [IW:0] count_q;

	// pending response
	logic [1:0] res_status_q;
	logic [63:0] res_value_q;
	logic [IW-1:0] res_slot_q;
	logic out_valid_q;
	rsp_t out_q;

	logic [IW-1:0] mp, other, rd_next;
	logic first, hit, is_insert, chain_end, relink_hit, out_free;

	assign mp = key_q[IW-1:0];
	assign other = mpw_q.key[IW-1:0];
	assign rd_next = IW'(rd.link - 1'b1);
	assign first = (steps_q == '0);
	assign hit = (first ? rd.used : 1'b1) && (rd.key == key_q);
	assign is_insert = (cmd_q == CMD_GET_OR_INSERT) || (cmd_q == CMD_WRITE);
	assign chain_end = (rd.link == '0) || (steps_q == LAST);
	assign relink_hit = (rd.link != '0) && (rd_next == mp);
	assign out_free = !out_valid_q || rsp.ready;

	chte_slot_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == LAST) state_d = S_IDLE;
			S_IDLE: if (req.valid) state_d = S_CHAIN;
			S_CHAIN: begin
				if (hit) begin
					state_d = S_DONE;
				end else if (first && !rd.used) begin
					state_d = is_insert ? S_NEW : S_DONE;
				end else if (chain_end) begin
					if (!is_insert || count_q >= FULL_COUNT) state_d = S_DONE;
					else state_d = S_FREE;
				end
			end
			S_FREE: if (!rd.used) state_d = (other != mp) ? S_RELINK : S_APPEND;
			S_RELINK: if (rd.link == '0 || relink_hit || steps_q == LAST) state_d = S_MOVE;
			S_MOVE: state_d = S_NEW;
			S_APPEND: state_d = S_NEW;
			S_NEW: state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// memory control
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = node_q;
		ram_wdata = rd;
		ram_raddr = node_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: ram_raddr = req.payload.lookup_key[IW-1:0];
			S_CHAIN: begin
				if (hit) begin
					ram_we = (cmd_q == CMD_WRITE);
					ram_wdata.value = wval_q;
				end else if (!(first && !rd.used) && !chain_end) begin
					ram_raddr = rd_next;
				end else begin
					ram_raddr = '0;
				end
			end
			S_FREE: ram_raddr = rd.used ? scan_q + 1'b1 : other;
			S_RELINK: begin
				ram_raddr = rd_next;
				ram_waddr = p_q;
				ram_we = relink_hit;
				ram_wdata.link = (IW+1)'(scan_q) + 1'b1;
			end
			S_MOVE: begin
				ram_we = 1'b1;
				ram_waddr = scan_q;
				ram_wdata = mpw_q;
			end
			S_APPEND: begin
				ram_we = 1'b1;
				ram_waddr = node_q;
				ram_wdata = tailw_q;
				ram_wdata.link = (IW+1)'(scan_q) + 1'b1;
			end
			S_NEW: begin
				ram_we = 1'b1;
				ram_waddr = target_q;
				ram_wdata.used = 1'b1;
				ram_wdata.key = key_q;
				ram_wdata.value = (cmd_q == CMD_WRITE) ? wval_q : '0;
				ram_wdata.link = '0;
			end
			S_DONE: ram_raddr = node_q;
			default: ram_raddr = node_q;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_NEW) count_q <= count_q + 1'b1;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// request context and results
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= req.payload.cmd;
				key_q <= req.payload.lookup_key;
				wval_q <= req.payload.write_value;
				node_q <= req.payload.lookup_key[IW-1:0];
				steps_q <= '0;
			end
			S_CHAIN: begin
				// keep the main slot's occupant and the chain tail for insertion
				if (first) mpw_q <= rd;
				tailw_q <= rd;
				if (hit) begin
					res_status_q <= ST_FOUND;
					res_value_q <= (cmd_q == CMD_WRITE) ? wval_q : rd.value;
					res_slot_q <= node_q;
				end else if (first && !rd.used) begin
					target_q <= mp;
					res_status_q <= ST_NOT_FOUND;
					res_value_q <= '0;
					res_slot_q <= '0;
				end else if (chain_end) begin
					scan_q <= '0;
					res_status_q <= (is_insert && count_q >= FULL_COUNT) ? ST_TABLE_FULL
						: ST_NOT_FOUND;
					res_value_q <= '0;
					res_slot_q <= '0;
				end else begin
					node_q <= rd_next;
					steps_q <= steps_q + 1'b1;
				end
			end
			S_FREE: begin
				if (rd.used) begin
					scan_q <= scan_q + 1'b1;
				end else begin
					p_q <= other;
					steps_q <= '0;
					target_q <= (other != mp) ? mp : scan_q;
				end
			end
			S_RELINK: begin
				p_q <= rd_next;
				steps_q <= steps_q + 1'b1;
			end
			S_NEW: begin
				res_status_q <= ST_INSERTED;
				res_value_q <= (cmd_q == CMD_WRITE) ? wval_q : '0;
				res_slot_q <= target_q;
			end
			S_DONE: begin
				if (out_free) begin
					out_q.status <= res_status_q;
					out_q.read_value <= res_value_q;
					out_q.slot_index <= 10'(res_slot_q);
				end
			end
			default: ;
		endcase
	end

	// occupancy never exceeds the slot count
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_COUNT)
		else $error("entry count overflow");

	// each insertion adds exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NEW |=> count_q == $past(count_q) + 1'b1)
		else $error("entry count not advanced on insert");

	// free scan only runs when a free slot exists, so it never wraps
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE && rd.used) |-> scan_q != LAST)
		else $error("free slot scan wrapped");

	// no entry is counted before the clearing sweep completes
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> count_q == '0)
		else $error("entries present during clear");

endmodule
`default_nettype wire

// ===== sim/tb_coalesced_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// tb_coalesced_hash_table_engine: self-checking bench for the hash table engine
// Drives requests over the req channel and checks every response against a
// behavioral table model in the bench or a directed row's fixed answer. The
// run opens with a directed table and follows with random requests aimed at
// chain collisions and main slot relocation. It closes with a few probes onto occupied main slots.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_coalesced_hash_table_engine;
	import chte_pkg::*;

	localparam int NSLOTS = 1024;
	localparam int IDLE_LIMIT = 20000;   // covers the clearing sweep and long scans
	localparam int DRAIN_CYCLES = 3000;  // worst insert: full scan plus full walk
	localparam int ITEMS_PER_PHASE = 113;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	chte_stream_if #(.item_t(req_t)) req_if ();
	chte_stream_if #(.item_t(rsp_t)) rsp_if ();

	coalesced_hash_table_engine #(.SLOTS(NSLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #5 clk = ~clk;

	// Shadow copy of the table, updated as each request is accepted.
	logic [63:0] shadow_keys [NSLOTS];
	logic [63:0] shadow_values [NSLOTS];
	logic [10:0] shadow_links [NSLOTS];
	bit shadow_used [NSLOTS];
	int shadow_count;

	rsp_t pending_rsp [$];   // responses owed by the block, oldest first
	logic [63:0] key_pool [$];  // keys already offered for insertion

	int mismatches = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	function automatic rsp_t table_apply(cmd_t cmd, logic [63:0] key, logic [63:0] wval);
		rsp_t r;
		int mp, node, tail, target, other, fr, p;
		bit found;
		mp = int'(key[9:0]);
		node = mp;
		tail = mp;
		found = 0;
		r = '0;
		// Walk the chain that starts at the main slot, bounded to the table size.
		if (shadow_used[mp]) begin
			for (int s = 0; s < NSLOTS; s++) begin
				tail = node;
				if (shadow_keys[node] == key) begin
					found = 1;
					break;
				end
				if (shadow_links[node] == 0)
					break;
				node = int'(shadow_links[node] - 11'd1) & (NSLOTS - 1);
			end
		end
		if (found) begin
			if (cmd == CMD_WRITE)
				shadow_values[node] = wval;
			r.status = ST_FOUND;
			r.read_value = shadow_values[node];
			r.slot_index = node[9:0];
			return r;
		end
		if (cmd != CMD_GET_OR_INSERT && cmd != CMD_WRITE) begin
			r.status = ST_NOT_FOUND;
			return r;
		end
		if (!shadow_used[mp]) begin
			target = mp;
		end else begin
			if (shadow_count >= NSLOTS) begin
				r.status = ST_TABLE_FULL;
				return r;
			end
			other = int'(shadow_keys[mp][9:0]);
			fr = 0;
			for (int i = 0; i < NSLOTS; i++) begin
				if (!shadow_used[i]) begin
					fr = i;
					break;
				end
			end
			if (other != mp) begin
				// Foreign occupant: relink its predecessor and move it out.
				p = other;
				for (int s = 0; s < NSLOTS; s++) begin
					if (shadow_links[p] == 0)
						break;
					if (int'(shadow_links[p]) - 1 == mp) begin
						shadow_links[p] = 11'(fr + 1);
						break;
					end
					p = int'(shadow_links[p] - 11'd1) & (NSLOTS - 1);
				end
				shadow_keys[fr] = shadow_keys[mp];
				shadow_values[fr] = shadow_values[mp];
				shadow_links[fr] = shadow_links[mp];
				shadow_used[fr] = 1;
				target = mp;
			end else begin
				shadow_links[tail] = 11'(fr + 1);
				target = fr;
			end
		end
		shadow_keys[target] = key;
		shadow_values[target] = (cmd == CMD_WRITE) ? wval : 64'd0;
		shadow_links[target] = '0;
		shadow_used[target] = 1;
		shadow_count++;
		r.status = ST_INSERTED;
		r.read_value = shadow_values[target];
		r.slot_index = target[9:0];
		return r;
	endfunction

	// Offer one request, hold it until the transaction, then queue the answer.
	task automatic send_req(cmd_t cmd, logic [63:0] key, logic [63:0] wval,
			bit typed, rsp_t typed_rsp);
		rsp_t predicted;
		if ($urandom_range(0, 99) < gap_pct) begin
			req_if.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.payload = '{cmd: cmd, lookup_key: key, write_value: wval};
		do @(posedge clk); while (!req_if.ready);
		predicted = table_apply(cmd, key, wval);
		pending_rsp.push_back(typed ? typed_rsp : predicted);
		if (cmd == CMD_GET_OR_INSERT || cmd == CMD_WRITE)
			key_pool.push_back(key);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_if.valid = 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
	endtask

	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		if (key_pool.size() != 0 && $urandom_range(0, 99) < 45)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		k = {$urandom, $urandom};
		// Crowd most new keys onto main slots 0 to 31 to build long chains.
		if ($urandom_range(0, 99) < 70)
			k[9:0] = 10'($urandom_range(0, 31));
		return k;
	endfunction

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return CMD_LOOKUP;
		if (r < 20) return CMD_SPARE;
		if (r < 60) return CMD_GET_OR_INSERT;
		return CMD_WRITE;
	endfunction

	typedef struct {
		cmd_t cmd;
		logic [63:0] key;
		logic [63:0] wval;
		bit typed;
		rsp_t rsp;
	} dir_row_t;

	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	dir_row_t dir_rows [] = '{
		'{CMD_LOOKUP, 64'd0, 64'd0, 1, '{ST_NOT_FOUND, 64'd0, 10'd0}},
		'{CMD_LOOKUP, ONES, ONES, 1, '{ST_NOT_FOUND, 64'd0, 10'd0}},
		'{CMD_SPARE, 64'd5, ONES, 1, '{ST_NOT_FOUND, 64'd0, 10'd0}},
		'{CMD_GET_OR_INSERT, 64'd0, ONES, 1, '{ST_INSERTED, 64'd0, 10'd0}},
		'{CMD_WRITE, ONES, ONES, 1, '{ST_INSERTED, ONES, 10'd1023}},
		'{CMD_LOOKUP, ONES, 64'd0, 1, '{ST_FOUND, ONES, 10'd1023}},
		'{CMD_WRITE, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1,
			'{ST_FOUND, 64'hAAAA_AAAA_AAAA_AAAA, 10'd0}},
		'{CMD_GET_OR_INSERT, 64'd0, 64'd7, 1,
			'{ST_FOUND, 64'hAAAA_AAAA_AAAA_AAAA, 10'd0}},
		'{CMD_GET_OR_INSERT, 64'd1024, 64'd9, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_WRITE, 64'd2048, 64'd5, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_LOOKUP, 64'd1, 64'd0, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_GET_OR_INSERT, 64'd1, 64'd0, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_LOOKUP, 64'd1024, 64'd0, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_LOOKUP, 64'd2048, 64'd0, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_LOOKUP, 64'd1, 64'd0, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_WRITE, 64'd3072, 64'd0, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_SPARE, 64'd1024, ONES, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_LOOKUP, 64'd4096, 64'd0, 0, '{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_WRITE, 64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555, 0,
			'{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_GET_OR_INSERT, 64'h7FFF_FFFF_FFFF_FC01, 64'd0, 0,
			'{ST_FOUND, 64'd0, 10'd0}},
		'{CMD_LOOKUP, 64'h8000_0000_0000_0001, 64'd0, 0, '{ST_FOUND, 64'd0, 10'd0}}
	};

	// Receiver: random back-pressure, plus a long hold-off when requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready = 1'b0;
		end else if (hold_left > 0) begin
			rsp_if.ready = 1'b0;
			hold_left--;
		end else begin
			rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Response checker: compare each transaction with the oldest expectation.
	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.payload;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: status %0d value %h slot %0d",
						got.status, got.read_value, got.slot_index);
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status || got.read_value !== want.read_value ||
						got.slot_index !== want.slot_index) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp status %0d value %h slot %0d, ",
							want.status, want.read_value, want.slot_index,
							"got status %0d value %h slot %0d",
							got.status, got.read_value, got.slot_index);
				end
			end
		end
	end

	// Watchdog: count cycles without any transaction on either channel.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d responses outstanding", pending_rsp.size());
			$display("coalesced_hash_table_engine test failed");
			$finish;
		end
	end

	initial begin
		rsp_t none;
		none = '0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < NSLOTS; i++) begin
			shadow_keys[i] = '0;
			shadow_values[i] = '0;
			shadow_links[i] = '0;
			shadow_used[i] = 0;
		end
		shadow_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass: reset state, extremes, collisions, relocation.
		foreach (dir_rows[i])
			send_req(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].wval,
				dir_rows[i].typed, dir_rows[i].rsp);
		wait_drained();

		// Random pass in four idling phases; drain between phases.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0; stall_pct = 0; hold_left = 400; end
				1: begin gap_pct = 50; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 50; end
				default: begin gap_pct = 35; stall_pct = 35; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_req(pick_cmd(), pick_key(), {$urandom, $urandom}, 0, none);
			wait_drained();
		end

		// Close with probes onto occupied main slots and the top slot.
		send_req(CMD_GET_OR_INSERT, 64'h0000_0001_0000_0405, 64'd0, 0, none);
		send_req(CMD_WRITE, ONES - 64'd1024, ONES, 0, none);
		send_req(CMD_LOOKUP, 64'h0000_0001_0000_0405, 64'd0, 0, none);
		send_req(CMD_WRITE, 64'd0, 64'h1234_5678_9ABC_DEF0, 0, none);
		send_req(CMD_GET_OR_INSERT, ONES, 64'd0, 0, none);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("coalesced_hash_table_engine test passed");
		else
			$display("coalesced_hash_table_engine test failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/chte_pkg.sv
hdl/chte_stream_if.sv
hdl/chte_slot_ram.sv
hdl/coalesced_hash_table_engine.sv
sim/tb_coalesced_hash_table_engine.sv
